/* src/ubx_pkg.sv */
// Shared types and constants for the binary GPS frame parser.
// Used by ubx_core, ubx_out_reg and ubx_frame_parser_top; no dependencies.
package ubx_pkg;

  localparam logic [7:0]  SYNC_ONE      = 8'hB5;
  localparam logic [7:0]  SYNC_TWO      = 8'h62;
  localparam logic [7:0]  VER_CLASS     = 8'h0A;
  localparam logic [7:0]  VER_ID        = 8'h04;
  localparam logic [15:0] MAX_LEN_RESET = 16'd220;

  // Frame position; codes above PH_CK_B are never entered
  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN_LO  = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK_A    = 4'd7,
    PH_CK_B    = 4'd8
  } phase_e;

  // One completed frame summary
  typedef struct packed {
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_len;
    logic        checksum_ok;
    logic        is_version_reply;
  } result_t;

endpackage

/* src/ubx_core.sv */
// Frame tracker: phase register, header fields, running Fletcher sums.
// Depends on ubx_pkg for phase codes, constants and the result struct.
module ubx_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  output logic              emit_o,
  output ubx_pkg::result_t  result_o
);

  ubx_pkg::phase_e phase_q, phase_d;
  logic [7:0]  class_q, class_d;
  logic [7:0]  id_q, id_d;
  logic [15:0] len_q, len_d;
  logic [15:0] count_q, count_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [7:0]  ck_a_q, ck_a_d;
  logic [15:0] max_len_q;

  logic [7:0]  base_a, base_b, add_a, add_b;
  logic [15:0] len_full;
  logic [15:0] count_inc;

  // Running sums restart at the class byte
  assign base_a    = (phase_q == ubx_pkg::PH_CLASS) ? 8'h00 : sum_a_q;
  assign base_b    = (phase_q == ubx_pkg::PH_CLASS) ? 8'h00 : sum_b_q;
  assign add_a     = base_a + rx_byte_i;
  assign add_b     = base_b + add_a;
  assign len_full  = {rx_byte_i, len_q[7:0]};
  assign count_inc = count_q + 16'd1;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      ubx_pkg::PH_SYNC2: begin
        phase_d = (rx_byte_i == ubx_pkg::SYNC_TWO) ? ubx_pkg::PH_CLASS : ubx_pkg::PH_SYNC1;
      end
      ubx_pkg::PH_CLASS:  phase_d = ubx_pkg::PH_ID;
      ubx_pkg::PH_ID:     phase_d = ubx_pkg::PH_LEN_LO;
      ubx_pkg::PH_LEN_LO: phase_d = ubx_pkg::PH_LEN_HI;
      ubx_pkg::PH_LEN_HI: begin
        if (len_full == 16'd0) begin
          phase_d = ubx_pkg::PH_CK_A;
        end else if (len_full > max_len_q) begin
          phase_d = ubx_pkg::PH_SYNC1;
        end else begin
          phase_d = ubx_pkg::PH_PAYLOAD;
        end
      end
      ubx_pkg::PH_PAYLOAD: begin
        if (count_inc >= len_q) phase_d = ubx_pkg::PH_CK_A;
      end
      ubx_pkg::PH_CK_A: phase_d = ubx_pkg::PH_CK_B;
      ubx_pkg::PH_CK_B: phase_d = ubx_pkg::PH_SYNC1;
      default: begin
        phase_d = (rx_byte_i == ubx_pkg::SYNC_ONE) ? ubx_pkg::PH_SYNC2 : ubx_pkg::PH_SYNC1;
      end
    endcase
  end

  // Header fields, counter and sums
  always_comb begin
    class_d = class_q;
    id_d    = id_q;
    len_d   = len_q;
    count_d = count_q;
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    ck_a_d  = ck_a_q;
    unique case (phase_q)
      ubx_pkg::PH_CLASS: begin
        class_d = rx_byte_i;
        sum_a_d = add_a;
        sum_b_d = add_b;
      end
      ubx_pkg::PH_ID: begin
        id_d    = rx_byte_i;
        sum_a_d = add_a;
        sum_b_d = add_b;
      end
      ubx_pkg::PH_LEN_LO: begin
        len_d   = {8'h00, rx_byte_i};
        sum_a_d = add_a;
        sum_b_d = add_b;
      end
      ubx_pkg::PH_LEN_HI: begin
        len_d   = len_full;
        count_d = 16'd0;
        sum_a_d = add_a;
        sum_b_d = add_b;
      end
      ubx_pkg::PH_PAYLOAD: begin
        count_d = count_inc;
        sum_a_d = add_a;
        sum_b_d = add_b;
      end
      ubx_pkg::PH_CK_A: ck_a_d = rx_byte_i;
      default: ;
    endcase
  end

  // Result of the word in hand, valid when the phase is the second checksum
  always_comb begin
    emit_o                    = (phase_q == ubx_pkg::PH_CK_B);
    result_o.msg_class        = class_q;
    result_o.msg_id           = id_q;
    result_o.payload_len      = len_q;
    result_o.checksum_ok      = (sum_a_q == ck_a_q) && (sum_b_q == rx_byte_i);
    result_o.is_version_reply = (class_q == ubx_pkg::VER_CLASS) &&
                                (id_q == ubx_pkg::VER_ID);
  end

  // Advance state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ubx_pkg::PH_SYNC1;
      class_q <= 8'h00;
      id_q    <= 8'h00;
      len_q   <= 16'd0;
      count_q <= 16'd0;
      sum_a_q <= 8'h00;
      sum_b_q <= 8'h00;
      ck_a_q  <= 8'h00;
    end else if (accept_i) begin
      phase_q <= phase_d;
      class_q <= class_d;
      id_q    <= id_d;
      len_q   <= len_d;
      count_q <= count_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      ck_a_q  <= ck_a_d;
    end
  end

  // Length limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= ubx_pkg::MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  // A frame in payload never counts past its length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == ubx_pkg::PH_PAYLOAD) |-> (count_q < len_q))
    else $error("payload count reached length while still in payload");

  // Oversized length drops the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && phase_q == ubx_pkg::PH_LEN_HI && len_full > max_len_q)
      |=> (phase_q == ubx_pkg::PH_SYNC1))
    else $error("oversized frame not dropped");

  // Every result returns the parser to hunting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && emit_o) |=> (phase_q == ubx_pkg::PH_SYNC1))
    else $error("parser did not resync after a result");

  // Payload is only entered with a non-zero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == ubx_pkg::PH_PAYLOAD) |-> (len_q != 16'd0))
    else $error("payload phase with zero length");

endmodule

/* src/ubx_out_reg.sv */
// Result register between the parser and the downstream receiver.
// Depends on ubx_pkg for the result struct.
module ubx_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  ubx_pkg::result_t  data_i,
  input  logic              ready_i,
  output logic              valid_o,
  output ubx_pkg::result_t  data_o
);

  logic             valid_q, valid_d;
  ubx_pkg::result_t data_q;

  // Fill on load, drain on take
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload until a new result loads
  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= data_i;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Never overwrite a result that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!valid_q || ready_i))
    else $error("result overwritten before it was taken");

  // A waiting result keeps its contents
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |=> (valid_q && $stable(data_q)))
    else $error("stalled result changed");

  // A load always shows up as a valid result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> valid_q)
    else $error("loaded result not presented");

endmodule

/* src/ubx_frame_parser_top.sv */
// Binary GPS frame parser, top level.
// Depends on ubx_pkg, ubx_core and ubx_out_reg.
//
// Usage:
//   Input channel: one received byte per word on rx_byte_i, with in_valid_i /
//   in_ready_o. Output channel: one frame summary per word (class, id,
//   payload length, checksum status, version-reply flag) with out_valid_o /
//   out_ready_i. The limit on payload length is written via cfg_we_i and
//   cfg_wdata_i and takes effect at the next length high byte.
//   Throughput: one byte per cycle while in_ready_o is high, set by the
//   update of the phase register and the running sums.
//   Result: the summary appears from the result register in the cycle after
//   the second checksum byte is accepted.
//   Reset: the parser hunts for the first sync byte, the result register is
//   empty and the length limit is 220.
//   Stall: bytes keep flowing while a result waits; only the second
//   checksum byte of the next frame is held off (in_ready_o low) while the
//   previous result is still untaken.
module ubx_frame_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  msg_class_o,
  output logic [7:0]  msg_id_o,
  output logic [15:0] payload_len_o,
  output logic        checksum_ok_o,
  output logic        is_version_reply_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic             accept;
  logic             emit;
  ubx_pkg::result_t result;
  ubx_pkg::result_t out_data;

  // Hold back only a word that would produce a result with no room for it
  assign in_ready_o = !(emit && out_valid_o && !out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  ubx_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .emit_o      (emit),
    .result_o    (result)
  );

  ubx_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept && emit),
    .data_i  (result),
    .ready_i (out_ready_i),
    .valid_o (out_valid_o),
    .data_o  (out_data)
  );

  assign msg_class_o        = out_data.msg_class;
  assign msg_id_o           = out_data.msg_id;
  assign payload_len_o      = out_data.payload_len;
  assign checksum_ok_o      = out_data.checksum_ok;
  assign is_version_reply_o = out_data.is_version_reply;

endmodule
